FILE: src/state_variable_audio_filter_defines.svh
// ----------------------------------------------------------------------------
// State variable audio filter: assertion macros
// Assertion macros shared by the filter RTL. They compile to nothing in
// synthesis builds.
// ----------------------------------------------------------------------------
`ifndef STATE_VARIABLE_AUDIO_FILTER_DEFINES_SVH
`define STATE_VARIABLE_AUDIO_FILTER_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, checked on every clock outside reset
`define SVF_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("svf assertion failed");
// Next-cycle implication, checked on every clock outside reset
`define SVF_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("svf assertion failed");
// Plain condition that holds on every clock outside reset
`define SVF_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("svf assertion failed");
`else
`define SVF_ASSERT_IMPLY(lbl, ante, cons)
`define SVF_ASSERT_NEXT(lbl, ante, cons)
`define SVF_ASSERT_ALWAYS(lbl, cond)
`endif
`endif

FILE: src/svf_pkg.sv
// ----------------------------------------------------------------------------
// State variable audio filter package
// Widths, register map, controller command bundle and the saturating
// fixed-point helpers shared by the controller, datapath and top level.
// ----------------------------------------------------------------------------
package svf_pkg;

   localparam int SAMPLE_W = 24;
   localparam int COEF_W   = 18;
   localparam int COUNT_W  = 3;
   localparam int ACC_W    = 32;
   localparam int PROD_W   = COEF_W + 1 + ACC_W;
   localparam int FRAC_W   = 16;
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;

   // Register map, indexed by paddr[3:2]
   localparam logic [1:0] REG_FREQ  = 2'd0;
   localparam logic [1:0] REG_DAMP  = 2'd1;
   localparam logic [1:0] REG_COUNT = 2'd2;

   // Register reset values (damping is about 1.8 in Q2.16)
   localparam logic [COEF_W-1:0]  FREQ_RESET  = 18'd0;
   localparam logic [COEF_W-1:0]  DAMP_RESET  = 18'd117965;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd1;

   typedef logic signed [ACC_W-1:0]    acc_type;
   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [PROD_W-1:0]   prod_type;

   // One-cycle commands from controller to datapath
   typedef struct packed {
      logic capture;   // latch the input sample
      logic mul_en;    // load the product register
      logic mul_damp;  // coefficient: damping instead of frequency
      logic mul_hp;    // operand: highpass instead of delayed bandpass
      logic low_en;    // lowpass from delayed lowpass plus product
      logic high_x;    // highpass from sample minus lowpass
      logic high_d;    // highpass minus damping product
      logic band_en;   // new bandpass, update delays and notch
      logic load_out;  // load the result register
   } cmd_type;

   // Saturate a sum that grew by one bit to the internal width
   function automatic acc_type sat_acc(input logic signed [ACC_W:0] v);
      acc_type r;
      if (v[ACC_W] != v[ACC_W-1]) begin
         r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         r = v[ACC_W-1:0];
      end
      return r;
   endfunction

   // Round a coefficient product to the internal format, floor shift, saturate
   function automatic acc_type coef_round(input prod_type p);
      logic signed [PROD_W:0]        s;
      logic signed [PROD_W-FRAC_W:0] q;
      acc_type                       r;
      s = {p[PROD_W-1], p} + (PROD_W+1)'(32768);
      q = s[PROD_W:FRAC_W];
      if (q[PROD_W-FRAC_W:ACC_W-1] != {(PROD_W-FRAC_W-ACC_W+2){q[PROD_W-FRAC_W]}}) begin
         r = q[PROD_W-FRAC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         r = q[ACC_W-1:0];
      end
      return r;
   endfunction

   // Saturate an internal value to the sample range
   function automatic sample_type sat_sample(input acc_type v);
      sample_type r;
      if (v[ACC_W-1:SAMPLE_W-1] != {(ACC_W-SAMPLE_W+1){v[ACC_W-1]}}) begin
         r = v[ACC_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: src/svf_ctrl.sv
// ----------------------------------------------------------------------------
// State variable audio filter controller
// Sequences the six steps of each filter pass, counts passes per sample and
// owns the input stall and the result valid.
// ----------------------------------------------------------------------------
module svf_ctrl #(
   parameter int MAX_OVERSAMPLE = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [svf_pkg::COUNT_W-1:0]  oversample_count,
   output svf_pkg::cmd_type             cmd
);

   localparam int CNT_W = $clog2(MAX_OVERSAMPLE + 1);
   localparam int CMP_W = (CNT_W > svf_pkg::COUNT_W) ? CNT_W : svf_pkg::COUNT_W;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_MUL_FB = 8'b0000_0010,
      ST_LOW    = 8'b0000_0100,
      ST_HIGH_X = 8'b0000_1000,
      ST_HIGH_D = 8'b0001_0000,
      ST_MUL_FH = 8'b0010_0000,
      ST_BAND   = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] remain_ff, remain_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CMP_W-1:0] count_ext;
   logic [CMP_W-1:0] passes;
   logic             accept;
   logic             out_free;

   // Clamp the pass count to one through MAX_OVERSAMPLE
   assign count_ext = CMP_W'(oversample_count);
   always_comb begin
      if (count_ext == '0) begin
         passes = CMP_W'(1);
      end else if (count_ext > CMP_W'(MAX_OVERSAMPLE)) begin
         passes = CMP_W'(MAX_OVERSAMPLE);
      end else begin
         passes = count_ext;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   // Advance the pass sequence
   always_comb begin
      state_in     = state_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               remain_in   = passes[CNT_W-1:0];
               state_in    = ST_MUL_FB;
            end
         end
         ST_MUL_FB: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_LOW;
         end
         ST_LOW: begin
            cmd.low_en   = 1'b1;
            cmd.mul_en   = 1'b1;
            cmd.mul_damp = 1'b1;
            state_in     = ST_HIGH_X;
         end
         ST_HIGH_X: begin
            cmd.high_x = 1'b1;
            state_in   = ST_HIGH_D;
         end
         ST_HIGH_D: begin
            cmd.high_d = 1'b1;
            state_in   = ST_MUL_FH;
         end
         ST_MUL_FH: begin
            cmd.mul_en = 1'b1;
            cmd.mul_hp = 1'b1;
            state_in   = ST_BAND;
         end
         ST_BAND: begin
            cmd.band_en = 1'b1;
            remain_in   = remain_ff - CNT_W'(1);
            state_in    = (remain_ff == CNT_W'(1)) ? ST_DONE : ST_MUL_FB;
         end
         ST_DONE: begin
            // Hold until the result register is free
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: src/svf_datapath.sv
// ----------------------------------------------------------------------------
// State variable audio filter datapath
// One shared coefficient multiplier, the saturating adders, the delayed
// bandpass and lowpass state and the result register.
// ----------------------------------------------------------------------------
module svf_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  svf_pkg::cmd_type            cmd,
   input  logic [svf_pkg::COEF_W-1:0]  freq_coeff,
   input  logic [svf_pkg::COEF_W-1:0]  damping,
   input  svf_pkg::sample_type         sample_in,
   output svf_pkg::sample_type         highpass_out,
   output svf_pkg::sample_type         bandpass_out,
   output svf_pkg::sample_type         lowpass_out,
   output svf_pkg::sample_type         notch_out
);

   svf_pkg::sample_type              x_ff;
   svf_pkg::prod_type                prod_ff, prod_in;
   svf_pkg::acc_type                 lp_ff, hp_ff, notch_ff;
   svf_pkg::acc_type                 band_ff, low_ff;
   svf_pkg::acc_type                 prod_rnd;
   svf_pkg::acc_type                 mul_opnd;
   svf_pkg::acc_type                 x_ext;
   logic [svf_pkg::COEF_W-1:0]       coef_sel;
   logic signed [svf_pkg::COEF_W:0]  mul_coef;
   svf_pkg::sample_type              hp_out_ff, bp_out_ff, lp_out_ff, notch_out_ff;

   // Select multiplier operands and form the exact product
   assign coef_sel = cmd.mul_damp ? damping : freq_coeff;
   assign mul_coef = {1'b0, coef_sel};
   assign mul_opnd = cmd.mul_hp ? hp_ff : band_ff;
   assign prod_in  = mul_coef * mul_opnd;
   assign prod_rnd = svf_pkg::coef_round(prod_ff);
   assign x_ext    = svf_pkg::ACC_W'(x_ff);

   // Working registers of the current pass
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff <= sample_in;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.low_en) begin
         lp_ff <= svf_pkg::sat_acc({low_ff[svf_pkg::ACC_W-1], low_ff}
                                   + {prod_rnd[svf_pkg::ACC_W-1], prod_rnd});
      end
      if (cmd.high_x) begin
         hp_ff <= svf_pkg::sat_acc({x_ext[svf_pkg::ACC_W-1], x_ext}
                                   - {lp_ff[svf_pkg::ACC_W-1], lp_ff});
      end else if (cmd.high_d) begin
         hp_ff <= svf_pkg::sat_acc({hp_ff[svf_pkg::ACC_W-1], hp_ff}
                                   - {prod_rnd[svf_pkg::ACC_W-1], prod_rnd});
      end
      if (cmd.band_en) begin
         notch_ff <= svf_pkg::sat_acc({hp_ff[svf_pkg::ACC_W-1], hp_ff}
                                      + {lp_ff[svf_pkg::ACC_W-1], lp_ff});
      end
   end

   // Delayed bandpass and lowpass state
   always_ff @(posedge clock) begin
      if (reset) begin
         band_ff <= '0;
         low_ff  <= '0;
      end else if (cmd.band_en) begin
         band_ff <= svf_pkg::sat_acc({prod_rnd[svf_pkg::ACC_W-1], prod_rnd}
                                     + {band_ff[svf_pkg::ACC_W-1], band_ff});
         low_ff  <= lp_ff;
      end
   end

   // Result register, loaded once per sample after the last pass
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         hp_out_ff    <= svf_pkg::sat_sample(hp_ff);
         bp_out_ff    <= svf_pkg::sat_sample(band_ff);
         lp_out_ff    <= svf_pkg::sat_sample(low_ff);
         notch_out_ff <= svf_pkg::sat_sample(notch_ff);
      end
   end

   assign highpass_out = hp_out_ff;
   assign bandpass_out = bp_out_ff;
   assign lowpass_out  = lp_out_ff;
   assign notch_out    = notch_out_ff;

endmodule

FILE: src/state_variable_audio_filter.sv
// ----------------------------------------------------------------------------
// State variable audio filter
// Two-integrator state variable filter on Q1.23 samples with highpass,
// bandpass, lowpass and notch outputs and an APB-style register port.
// ----------------------------------------------------------------------------
// Each sample runs oversample_count filter passes (0 runs one pass, values
// above MAX_OVERSAMPLE run MAX_OVERSAMPLE). Each pass steps through the
// single shared 19x32 multiplier and its saturating adders, and the result
// register is loaded after the last pass. The next sample can be accepted
// once that result is loaded, even while it still waits under rsp_stall;
// the new sample's own result then holds until the result register is taken.
// Registers: 0x0 freq_coeff (Q2.16), 0x4 damping (Q2.16, reset 1.8),
// 0x8 oversample_count. Write them only while the filter is idle.
// ----------------------------------------------------------------------------
`include "state_variable_audio_filter_defines.svh"

module state_variable_audio_filter #(
   parameter int MAX_OVERSAMPLE = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   // Sample input
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [23:0]            req_sample_in,
   // Filter result
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [23:0]            rsp_highpass_out,
   output logic signed [23:0]            rsp_bandpass_out,
   output logic signed [23:0]            rsp_lowpass_out,
   output logic signed [23:0]            rsp_notch_out,
   // Register port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [svf_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [svf_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [svf_pkg::DATA_W-1:0]    csr_prdata,
   output logic                          csr_pready
);

   logic [svf_pkg::COEF_W-1:0]  freq_ff;
   logic [svf_pkg::COEF_W-1:0]  damp_ff;
   logic [svf_pkg::COUNT_W-1:0] count_ff;
   logic [1:0]                  reg_idx;
   logic                        csr_wr;
   svf_pkg::cmd_type            cmd;

   // Register port: decode and write
   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff  <= svf_pkg::FREQ_RESET;
         damp_ff  <= svf_pkg::DAMP_RESET;
         count_ff <= svf_pkg::COUNT_RESET;
      end else if (csr_wr) begin
         unique case (reg_idx)
            svf_pkg::REG_FREQ:  freq_ff  <= csr_pwdata[svf_pkg::COEF_W-1:0];
            svf_pkg::REG_DAMP:  damp_ff  <= csr_pwdata[svf_pkg::COEF_W-1:0];
            svf_pkg::REG_COUNT: count_ff <= csr_pwdata[svf_pkg::COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Register read-back
   always_comb begin
      unique case (reg_idx)
         svf_pkg::REG_FREQ:  csr_prdata = svf_pkg::DATA_W'(freq_ff);
         svf_pkg::REG_DAMP:  csr_prdata = svf_pkg::DATA_W'(damp_ff);
         svf_pkg::REG_COUNT: csr_prdata = svf_pkg::DATA_W'(count_ff);
         default:            csr_prdata = '0;
      endcase
   end

   svf_ctrl #(
      .MAX_OVERSAMPLE (MAX_OVERSAMPLE)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .oversample_count (count_ff),
      .cmd              (cmd)
   );

   svf_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .freq_coeff   (freq_ff),
      .damping      (damp_ff),
      .sample_in    (req_sample_in),
      .highpass_out (rsp_highpass_out),
      .bandpass_out (rsp_bandpass_out),
      .lowpass_out  (rsp_lowpass_out),
      .notch_out    (rsp_notch_out)
   );

   // Accepted sample blocks the input until its passes are done and its result is loaded
   `SVF_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   // Never overwrite a result that is still waiting
   `SVF_ASSERT_IMPLY(a_no_result_overrun, cmd.load_out, !rsp_valid || !rsp_stall)
   // Datapath steps apart from the multiplier load are mutually exclusive
   `SVF_ASSERT_ALWAYS(a_one_step, $onehot0({cmd.capture, cmd.low_en, cmd.high_x,
                                            cmd.high_d, cmd.band_en, cmd.load_out}))

endmodule
